>>> src/sbdt_pkg.sv
// Shared types and constants for the signed binary to decimal text converter.
package sbdt_pkg;

	localparam int VALUE_W     = 64;
	localparam int CHAR_W      = 6;
	localparam int DIGIT_W     = 4;
	localparam int BCD_DIGITS  = 20;
	localparam int BCD_W       = BCD_DIGITS * DIGIT_W;
	localparam int POS_W       = $clog2(BCD_DIGITS);
	localparam int CNT_W       = $clog2(VALUE_W);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

	// Word carried from the front to the back: sign and unsigned magnitude.
	typedef struct packed {
		logic               negative;
		logic [VALUE_W-1:0] mag;
	} sbdt_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sbdt_qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_LOCATE,
		ST_SIGN,
		ST_DIGITS
	} sbdt_state_t;

endpackage

>>> src/sbdt_front.sv
// Front end: takes a value, splits it into sign and magnitude, hands it to the queue.
module sbdt_front import sbdt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [VALUE_W-1:0]  value,
	input  sbdt_qstat_t                q_status,
	output logic                       busy,
	output logic                       push,
	output sbdt_word_t                 push_word
);

	logic       valid_s1;
	sbdt_word_t word_s1;
	logic       accept;
	sbdt_word_t classified;

	assign push      = valid_s1 && !q_status.full;
	assign busy      = valid_s1 && q_status.full;
	assign accept    = start && !busy;
	assign push_word = word_s1;

	always_comb begin
		classified.negative = value[VALUE_W-1];
		// Two's complement negate; the most negative value stays correct as unsigned.
		classified.mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= classified;
		end
	end

endmodule

>>> src/sbdt_queue.sv
// Short queue of classified words between the front and the back.
module sbdt_queue import sbdt_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sbdt_word_t  push_word,
	input  logic        pop,
	output sbdt_word_t  pop_word,
	output sbdt_qstat_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbdt_word_t             mem_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_word     = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue read while empty");
`endif

endmodule

>>> src/sbdt_back.sv
// Back end: double-dabble conversion, leading digit search and character output.
module sbdt_back import sbdt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  sbdt_qstat_t         q_status,
	input  sbdt_word_t          q_word,
	output logic                pop,
	output logic                strobe,
	output logic [CHAR_W-1:0]   character,
	output logic                last
);

	sbdt_state_t          state_q, state_d;
	logic [BCD_W-1:0]     bcd_q, bcd_d, bcd_adj;
	logic [VALUE_W-1:0]   bin_q, bin_d;
	logic                 neg_q, neg_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [POS_W-1:0]     pos_q, pos_d, lead_pos;
	logic [DIGIT_W-1:0]   cur_digit;
	logic                 strobe_q, strobe_d;
	logic [CHAR_W-1:0]    char_q, char_d;
	logic                 last_q, last_d;

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;
	assign cur_digit = bcd_q[{pos_q, 2'b00} +: DIGIT_W];

	// Add three to every digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
				bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) : bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	// Highest nonzero digit; zero falls back to the units digit.
	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] != '0) begin
				lead_pos = POS_W'(i);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		bcd_d    = bcd_q;
		bin_d    = bin_q;
		neg_d    = neg_q;
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		strobe_d = 1'b0;
		char_d   = char_q;
		last_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					pop     = 1'b1;
					bin_d   = q_word.mag;
					neg_d   = q_word.negative;
					bcd_d   = '0;
					cnt_d   = '0;
					state_d = ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
				bin_d = {bin_q[VALUE_W-2:0], 1'b0};
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VALUE_W - 1)) begin
					state_d = ST_LOCATE;
				end
			end
			ST_LOCATE: begin
				pos_d   = lead_pos;
				state_d = neg_q ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				strobe_d = 1'b1;
				char_d   = CHAR_MINUS;
				state_d  = ST_DIGITS;
			end
			ST_DIGITS: begin
				strobe_d = 1'b1;
				char_d   = CHAR_ZERO + CHAR_W'(cur_digit);
				last_d   = (pos_q == '0);
				if (pos_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					pos_d = pos_q - POS_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		bcd_q  <= bcd_d;
		bin_q  <= bin_d;
		neg_q  <= neg_d;
		cnt_q  <= cnt_d;
		pos_q  <= pos_d;
		char_q <= char_d;
		last_q <= last_d;
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGITS) |-> (pos_q < POS_W'(BCD_DIGITS)))
		else $error("digit position out of range");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && char_q == CHAR_MINUS) |-> !last_q)
		else $error("minus sign marked last");
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |=> !strobe_q)
		else $error("character directly after last");
	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_CONVERT))
		else $error("dequeued word not converted");
`endif

endmodule

>>> src/signed_binary_to_decimal_text.sv
// Top level: signed 64-bit integer to decimal ASCII text.
//
//   channel  | signals                  | handshake
//   ---------+--------------------------+-------------------------------
//   input    | value                    | taken when start && !busy
//   result   | character, last          | one cycle, marked by strobe
//
// Each value gives n = 1..20 characters and passes the converter in order: a
// dequeue, 64 shift-and-adjust steps of the double-dabble loop, a search for the
// leading digit, then one character a cycle. Characters of one value come on
// consecutive cycles. The front holds one word and the queue QUEUE_DEPTH more,
// so busy rises only when both are full; the receiver never stalls the output.
// Reset clears all control state.
module signed_binary_to_decimal_text import sbdt_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      strobe,
	output logic [CHAR_W-1:0]         character,
	output logic                      last
);

	sbdt_qstat_t q_status;
	sbdt_word_t  push_word;
	sbdt_word_t  pop_word;
	logic        push;
	logic        pop;

	sbdt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.q_status  (q_status),
		.busy      (busy),
		.push      (push),
		.push_word (push_word)
	);

	sbdt_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.status    (q_status)
	);

	sbdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_word    (pop_word),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last)
	);

endmodule
